>>> rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// No dependencies; the files that use it refer to it by scoped names.
package pcxrle_pkg;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int SCAN_W   = 18;
  localparam int PLANES_W = 3;

  localparam logic [1:0] REG_BPL    = 2'd0;
  localparam logic [1:0] REG_PLANES = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_ROWS   = 2'd3;

  localparam logic [1:0] COUNT_TAG  = 2'b11;
  localparam logic [7:0] COUNT_MASK = 8'h3F;

  // One unit of work for the back end: a literal, or a run value with its count
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] len;
    logic       is_run;
  } cmd_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [15:0]         bpl;
    logic [PLANES_W-1:0] planes;
    logic [SCAN_W-1:0]   width;
    logic [15:0]         rows;
  } eff_cfg_t;

endpackage

>>> rtl/pcxrle_if.sv
// Valid/ready channel interfaces for coded input bytes and decoded results.
// Standalone; no package dependency.
interface pcxrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;

  modport source(output valid, output coded_byte, input ready);
  modport sink(input valid, input coded_byte, output ready);
endinterface

interface pcxrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       end_of_row;
  logic       end_of_image;
  logic       error;
  logic       last;

  modport source(output valid, output pixel, output end_of_row, output end_of_image,
                 output error, output last, input ready);
  modport sink(input valid, input pixel, input end_of_row, input end_of_image,
               input error, input last, output ready);
endinterface

>>> rtl/pcxrle_regs.sv
// APB-style register file and clamped effective configuration.
// Depends on pcxrle_pkg.
module pcxrle_regs #(
  parameter int MAX_PLANES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxrle_pkg::ADDR_W-1:0] paddr,
  input  logic [pcxrle_pkg::DATA_W-1:0] pwdata,
  output logic [pcxrle_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output pcxrle_pkg::eff_cfg_t          eff
);

  localparam int PW = pcxrle_pkg::PLANES_W;
  localparam int SW = pcxrle_pkg::SCAN_W;
  localparam logic [PW-1:0] MAXP = PW'(MAX_PLANES);

  logic [15:0]   bpl;
  logic [PW-1:0] planes;
  logic [15:0]   width;
  logic [15:0]   rows;
  logic [1:0]    idx;
  logic          wr;

  logic [15:0]   bpl_e;
  logic [PW-1:0] planes_e;
  logic [15:0]   width_e;
  logic [15:0]   rows_e;
  logic [SW:0]   scan_len;
  pcxrle_pkg::eff_cfg_t eff_next;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpl    <= 16'd1;
      planes <= PW'(1);
      width  <= 16'd1;
      rows   <= 16'd1;
    end else if (wr) begin
      case (idx)
        pcxrle_pkg::REG_BPL:    bpl    <= pwdata[15:0];
        pcxrle_pkg::REG_PLANES: planes <= pwdata[PW-1:0];
        pcxrle_pkg::REG_WIDTH:  width  <= pwdata[15:0];
        pcxrle_pkg::REG_ROWS:   rows   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pcxrle_pkg::REG_BPL:    prdata = {16'd0, bpl};
      pcxrle_pkg::REG_PLANES: prdata = {{(pcxrle_pkg::DATA_W-PW){1'b0}}, planes};
      pcxrle_pkg::REG_WIDTH:  prdata = {16'd0, width};
      pcxrle_pkg::REG_ROWS:   prdata = {16'd0, rows};
      default:                prdata = '0;
    endcase
  end

  // Zero acts as one; plane count saturates at the build limit; width clamps to the scanline
  always_comb begin
    bpl_e   = (bpl == 16'd0) ? 16'd1 : bpl;
    rows_e  = (rows == 16'd0) ? 16'd1 : rows;
    width_e = (width == 16'd0) ? 16'd1 : width;
    if (planes == '0) begin
      planes_e = PW'(1);
    end else if (planes > MAXP) begin
      planes_e = MAXP;
    end else begin
      planes_e = planes;
    end
    scan_len = (SW+1)'(planes_e) * (SW+1)'(bpl_e);
    eff_next.bpl    = bpl_e;
    eff_next.planes = planes_e;
    eff_next.rows   = rows_e;
    eff_next.width  = ((SW+1)'(width_e) < scan_len) ? SW'(width_e) : scan_len[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff.bpl    <= 16'd1;
      eff.planes <= PW'(1);
      eff.width  <= SW'(1);
      eff.rows   <= 16'd1;
    end else begin
      eff <= eff_next;
    end
  end

endmodule

>>> rtl/pcxrle_front.sv
// Front end: accepts coded bytes, strips count bytes and issues commands.
// Depends on pcxrle_pkg and pcxrle_if.
module pcxrle_front (
  input  logic              clk,
  input  logic              rst,
  pcxrle_in_if.sink         coded,
  input  logic              q_full,
  output logic              push,
  output pcxrle_pkg::cmd_t  cmd
);

  logic       pending;
  logic [5:0] run_len;
  logic       acc;
  logic       is_count;

  assign coded.ready = !q_full;
  assign acc         = coded.valid && coded.ready;
  assign is_count    = (coded.coded_byte[7:6] == pcxrle_pkg::COUNT_TAG);
  assign push        = acc && (pending || !is_count);

  always_comb begin
    cmd.data   = coded.coded_byte;
    cmd.len    = pending ? run_len : 6'd1;
    cmd.is_run = pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (acc) begin
      pending <= !pending && is_count;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !pending && is_count) begin
      run_len <= 6'(coded.coded_byte & pcxrle_pkg::COUNT_MASK);
    end
  end

endmodule

>>> rtl/pcxrle_queue.sv
// Two-entry command queue between front and back ends.
// Depends on pcxrle_pkg.
module pcxrle_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pcxrle_pkg::cmd_t  cmd_in,
  output logic              full,
  output logic              valid,
  output pcxrle_pkg::cmd_t  cmd_out,
  input  logic              pop
);

  pcxrle_pkg::cmd_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign cmd_out = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> rtl/pcxrle_back.sv
// Back end: expands commands one byte a cycle unless the result stalls, tracks
// line, plane and row position, flags run errors and holds the result register. Uses pcxrle_pkg.
module pcxrle_back #(
  parameter int PLANE_W = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pcxrle_pkg::eff_cfg_t  cfg,
  input  logic                  q_valid,
  input  pcxrle_pkg::cmd_t      cmd,
  output logic                  pop,
  pcxrle_out_if.source          result
);

  localparam int PW = pcxrle_pkg::PLANES_W;
  localparam int SW = pcxrle_pkg::SCAN_W;

  logic               halted;
  logic [5:0]         rem;
  logic [7:0]         cur_data;
  logic [15:0]        lo;
  logic [PLANE_W-1:0] pl;
  logic [SW-1:0]      scan;
  logic [15:0]        row;

  logic               o_valid;
  logic [7:0]         o_pixel;
  logic               o_eor;
  logic               o_eoi;
  logic               o_err;
  logic               o_last;

  logic               adv;
  logic               busy;
  logic [SW-1:0]      scan_n;
  logic               kept;
  logic               eor;
  logic               eoi;
  logic               later_kept;
  logic [16:0]        row_p1;
  logic [15:0]        lo_p1;
  logic               line_end;
  logic [PLANE_W:0]   pl_p1;
  logic               plane_end;
  logic               row_end;
  logic               ovf;

  assign result.valid        = o_valid;
  assign result.pixel        = o_pixel;
  assign result.end_of_row   = o_eor;
  assign result.end_of_image = o_eoi;
  assign result.error        = o_err;
  assign result.last         = o_last;

  assign adv  = !o_valid || result.ready;
  assign busy = (rem != 6'd0);
  assign pop  = adv && !busy && q_valid;

  always_comb begin
    scan_n     = scan + SW'(1);
    kept       = scan < cfg.width;
    eor        = (scan == cfg.width - SW'(1));
    row_p1     = {1'b0, row} + 17'd1;
    eoi        = eor && (row_p1 >= {1'b0, cfg.rows});
    // Within a run no line end falls before its final byte, so scan only rises
    later_kept = (rem != 6'd1) && (scan_n < cfg.width);
    lo_p1      = lo + 16'd1;
    line_end   = lo_p1 >= cfg.bpl;
    pl_p1      = {1'b0, pl} + (PLANE_W+1)'(1);
    plane_end  = PW'(pl_p1) >= cfg.planes;
    row_end    = row_p1 >= {1'b0, cfg.rows};
    ovf        = ({1'b0, lo} + 17'(cmd.len)) > {1'b0, cfg.bpl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted  <= 1'b0;
      rem     <= 6'd0;
      lo      <= 16'd0;
      pl      <= '0;
      scan    <= '0;
      row     <= 16'd0;
      o_valid <= 1'b0;
    end else if (adv) begin
      if (busy) begin
        o_valid <= kept;
        rem     <= rem - 6'd1;
        if (line_end) begin
          lo <= 16'd0;
          if (plane_end) begin
            pl   <= '0;
            scan <= '0;
            row  <= row_end ? 16'd0 : row_p1[15:0];
          end else begin
            pl   <= pl_p1[PLANE_W-1:0];
            scan <= scan_n;
          end
        end else begin
          lo   <= lo_p1;
          scan <= scan_n;
        end
      end else begin
        o_valid <= 1'b0;
        // Drop everything once halted
        if (q_valid && !halted) begin
          if (cmd.is_run && ovf) begin
            o_valid <= 1'b1;
            halted  <= 1'b1;
          end else begin
            rem <= cmd.len;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy) begin
        o_pixel <= cur_data;
        o_eor   <= eor;
        o_eoi   <= eoi;
        o_err   <= 1'b0;
        o_last  <= !later_kept;
      end else begin
        cur_data <= cmd.data;
        o_pixel  <= 8'd0;
        o_eor    <= 1'b0;
        o_eoi    <= 1'b0;
        o_err    <= 1'b1;
        o_last   <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder, top level. A literal byte passes through
// the command queue and the back end's command registers into the result
// register. The back end takes each command from the queue in a step of its
// own, then expands its bytes and takes no new command until done; count bytes are
// absorbed by the front end alone. Reset (rst, synchronous) clears all
// position counters and the halt flag, and sets every register to 1.
module pcx_rle_scanline_decoder #(
  parameter int MAX_PLANES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  pcxrle_in_if.sink                     coded,
  pcxrle_out_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxrle_pkg::ADDR_W-1:0] paddr,
  input  logic [pcxrle_pkg::DATA_W-1:0] pwdata,
  output logic [pcxrle_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int PLANE_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  pcxrle_pkg::eff_cfg_t eff;
  pcxrle_pkg::cmd_t     push_cmd;
  pcxrle_pkg::cmd_t     head_cmd;
  logic                 push;
  logic                 q_full;
  logic                 q_valid;
  logic                 pop;

  pcxrle_regs #(
    .MAX_PLANES(MAX_PLANES)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff     (eff)
  );

  pcxrle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .coded  (coded),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  pcxrle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .valid   (q_valid),
    .cmd_out (head_cmd),
    .pop     (pop)
  );

  pcxrle_back #(
    .PLANE_W(PLANE_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (eff),
    .q_valid (q_valid),
    .cmd     (head_cmd),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> test/pcxrle_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the PCX run-length scanline decoder: keeps its own copy of the
// registers and position counters and queues the pixels each coded byte yields.
// Depends on pcxrle_pkg for the register indexes and the count-byte tag.
package pcxrle_tb_pkg;

  typedef struct packed {
    logic [7:0] pixel;
    logic       end_of_row;
    logic       end_of_image;
    logic       error;
    logic       last;
  } pixel_res_t;

  class pcx_scoreboard;
    logic [15:0] bpl_r;
    logic [2:0]  planes_r;
    logic [15:0] width_r;
    logic [15:0] rows_r;

    bit          run_armed;
    logic [5:0]  run_n;
    logic [15:0] line_off;
    logic [1:0]  plane_idx;
    logic [17:0] scan_pos;
    logic [15:0] row_idx;
    bit          halted;

    pixel_res_t  pixel_q[$];
    int unsigned fails;

    function new();
      bpl_r = 16'd1;
      planes_r = 3'd1;
      width_r = 16'd1;
      rows_r = 16'd1;
      run_armed = 1'b0;
      run_n = '0;
      line_off = '0;
      plane_idx = '0;
      scan_pos = '0;
      row_idx = '0;
      halted = 1'b0;
      fails = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        pcxrle_pkg::REG_BPL:    bpl_r = v[15:0];
        pcxrle_pkg::REG_PLANES: planes_r = v[2:0];
        pcxrle_pkg::REG_WIDTH:  width_r = v[15:0];
        pcxrle_pkg::REG_ROWS:   rows_r = v[15:0];
        default: ;
      endcase
    endfunction

    function int eff_bpl();
      return (bpl_r == 0) ? 1 : int'(bpl_r);
    endfunction

    function int eff_planes();
      if (planes_r == 0) return 1;
      if (planes_r > 4) return 4;
      return int'(planes_r);
    endfunction

    function int eff_rows();
      return (rows_r == 0) ? 1 : int'(rows_r);
    endfunction

    function int eff_width();
      int w;
      int s;
      w = (width_r == 0) ? 1 : int'(width_r);
      s = eff_planes() * eff_bpl();
      return (w < s) ? w : s;
    endfunction

    // Bytes a run may still cover before the plane line ends; negative after
    // a register change has left the offset past the new line length
    function int line_room();
      return eff_bpl() - int'(line_off);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // Decode one byte: queue it if it lies within the kept width, then advance
    function void put_byte(logic [7:0] d);
      int w;
      int p;
      int r;
      pixel_res_t res;
      w = eff_width();
      if (int'(scan_pos) < w) begin
        res.pixel = d;
        res.end_of_row = (int'(scan_pos) == w - 1);
        res.end_of_image = res.end_of_row && (int'(row_idx) + 1 >= eff_rows());
        res.error = 1'b0;
        res.last = 1'b0;
        pixel_q.push_back(res);
      end
      scan_pos = scan_pos + 18'd1;
      line_off = line_off + 16'd1;
      if (int'(line_off) >= eff_bpl()) begin
        line_off = '0;
        p = int'(plane_idx) + 1;
        if (p >= eff_planes()) begin
          p = 0;
          scan_pos = '0;
          r = int'(row_idx) + 1;
          if (r >= eff_rows()) r = 0;
          row_idx = r[15:0];
        end
        plane_idx = p[1:0];
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int n0;
      int n;
      pixel_res_t res;
      if (halted) return;
      n0 = pixel_q.size();
      if (run_armed) begin
        n = int'(run_n);
        run_armed = 1'b0;
        run_n = '0;
        // a run may not spill into the next plane line
        if (int'(line_off) + n > eff_bpl()) begin
          res = '0;
          res.error = 1'b1;
          res.last = 1'b1;
          pixel_q.push_back(res);
          halted = 1'b1;
          return;
        end
        repeat (n) put_byte(b);
      end else if (b[7:6] == pcxrle_pkg::COUNT_TAG) begin
        run_armed = 1'b1;
        run_n = b[5:0];
        return;
      end else begin
        put_byte(b);
      end
      if (pixel_q.size() > n0) pixel_q[pixel_q.size() - 1].last = 1'b1;
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(pixel_res_t got);
      pixel_res_t want;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        fails++;
        return;
      end
      want = pixel_q.pop_front();
      cmp_field("pixel", want.pixel, got.pixel);
      cmp_field("end_of_row", 8'(want.end_of_row), 8'(got.end_of_row));
      cmp_field("end_of_image", 8'(want.end_of_image), 8'(got.end_of_image));
      cmp_field("error", 8'(want.error), 8'(got.error));
      cmp_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for pcx_rle_scanline_decoder: drives coded bytes and
// register writes through several geometries, checks every decoded item.
// Needs pcxrle_pkg, the channel interfaces and pcxrle_tb_pkg.
module tb_top;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 1200;
  localparam int HOLD_CYCLES   = 400;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pcxrle_pkg::ADDR_W-1:0] paddr;
  logic [pcxrle_pkg::DATA_W-1:0] pwdata;
  logic [pcxrle_pkg::DATA_W-1:0] prdata;
  logic                          pready;

  pcxrle_in_if  coded_ch();
  pcxrle_out_if result_ch();

  int snd_idle;
  int rcv_idle;
  bit hold_req;
  bit rcv_hold;
  int stall_cycles;

  pcxrle_tb_pkg::pcx_scoreboard sb = new();

  pcx_rle_scanline_decoder dut (
    .clk(clk),
    .rst(rst),
    .coded(coded_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle);
    end
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result('{result_ch.pixel, result_ch.end_of_row, result_ch.end_of_image,
                        result_ch.error, result_ch.last});
  end

  initial begin
    rcv_hold = 1'b0;
    wait (hold_req);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  // Watchdog: count cycles in which no item and no register write moves
  always @(posedge clk) begin
    if (rst || (coded_ch.valid && coded_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      coded_ch.valid <= 1'b0;
      @(posedge clk);
    end
    coded_ch.valid <= 1'b1;
    coded_ch.coded_byte <= b;
    @(posedge clk);
    while (!coded_ch.ready) @(posedge clk);
    sb.note_byte(b);
  endtask

  // Mostly plain literals, the rest runs that fit the plane line
  task automatic send_random(input int n_items);
    int sent;
    int room;
    int run_n;
    sent = 0;
    while (sent < n_items) begin
      room = sb.line_room();
      if (room >= 0 && $urandom_range(0, 99) < 40) begin
        run_n = $urandom_range(0, (room < 63) ? room : 63);
        send_byte({pcxrle_pkg::COUNT_TAG, run_n[5:0]});
        send_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(0, 8'hBF)));
        sent += 1;
      end
    end
  endtask

  // Drop valid, wait for every pending item, then let any padding run finish
  task automatic settle();
    coded_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_geometry(input logic [31:0] bpl, input logic [31:0] planes,
                              input logic [31:0] width, input logic [31:0] rows);
    write_reg(pcxrle_pkg::REG_BPL, bpl);
    write_reg(pcxrle_pkg::REG_PLANES, planes);
    write_reg(pcxrle_pkg::REG_WIDTH, width);
    write_reg(pcxrle_pkg::REG_ROWS, rows);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int room;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    coded_ch.valid = 1'b0;
    coded_ch.coded_byte = '0;
    snd_idle = 24;
    rcv_idle = 51;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: one pixel per scanline, one row per image
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'h3F);
    send_byte(8'hC1);   // run of one whose value looks like a count
    send_byte(8'hFF);
    send_byte(8'hC0);   // zero count: value dropped
    send_byte(8'hC5);
    settle();

    // Three planes of four, five kept: padding runs and row wrap
    set_geometry(4, 3, 5, 2);
    send_byte(8'hC4);
    send_byte(8'h5A);
    send_byte(8'h11);
    send_byte(8'hC3);
    send_byte(8'h22);
    send_byte(8'hC4);
    send_byte(8'h33);
    send_byte(8'h40);
    send_random(40);
    settle();

    // Zero registers act as one; upper bits of the bus are dropped
    set_geometry(32'hABCD_0000, 32'hFFFF_FFF8, 0, 0);
    send_random(30);
    settle();

    // Planes above the maximum clamp, width clamps to the scanline
    set_geometry(7, 7, 65535, 3);
    send_random(30);
    hold_req <= 1'b1;
    send_random(30);
    settle();

    snd_idle = 51;
    rcv_idle = 24;
    set_geometry(65535, 4, 65535, 65535);
    send_byte(8'hFF);   // longest run
    send_byte(8'h99);
    send_random(40);
    settle();

    set_geometry(3, 1, 2, 4);
    send_random(50);
    settle();

    snd_idle = 0;
    rcv_idle = 0;
    set_geometry(16, 2, 20, 1);
    send_random(50);
    // one byte past the room left in the plane line halts the block
    room = sb.line_room();
    send_byte({pcxrle_pkg::COUNT_TAG, 6'(room + 1)});
    send_byte(8'h77);
    send_random(6);
    settle();

    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pcxrle_pkg.sv
rtl/pcxrle_if.sv
rtl/pcxrle_regs.sv
rtl/pcxrle_front.sv
rtl/pcxrle_queue.sv
rtl/pcxrle_back.sv
rtl/pcx_rle_scanline_decoder.sv
test/pcxrle_tb_pkg.sv
test/tb_top.sv
